/* src/tod_pkg.sv */
// ----------------------------------------------------------------------------
// Time-of-day clock package
// Shared types, key codes, limits and helper functions for the settable
// time-of-day clock.
// ----------------------------------------------------------------------------
package tod_pkg;

    localparam int unsigned CFG_IDX_W = 2;

    localparam logic [CFG_IDX_W-1:0] CFG_SCANS_PER_SECOND = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_BLINK_SHOW_AT    = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_BLINK_PERIOD     = 2'd2;

    localparam logic [15:0] SCANS_PER_SECOND_RST = 16'd10;
    localparam logic [15:0] BLINK_SHOW_AT_RST    = 16'd20000;
    localparam logic [15:0] BLINK_PERIOD_RST     = 16'd60000;

    localparam logic [4:0] KEY_UP   = 5'd4;
    localparam logic [4:0] KEY_DOWN = 5'd12;
    localparam logic [4:0] KEY_NEXT = 5'd8;
    localparam logic [4:0] KEY_PREV = 5'd16;
    localparam logic [4:0] KEY_MODE = 5'd13;

    localparam logic [5:0] SECONDS_PER_MINUTE = 6'd60;
    localparam logic [5:0] MINUTES_PER_HOUR   = 6'd60;
    localparam logic [5:0] HOURS_PER_DAY      = 6'd24;

    localparam logic [15:0] BLINK_BLANK_AT = 16'd1;

    typedef enum logic [1:0] {
        MODE_RUN      = 2'd0,
        MODE_SET_SEC  = 2'd1,
        MODE_SET_MIN  = 2'd2,
        MODE_SET_HOUR = 2'd3
    } mode_t;

    typedef struct packed {
        logic [15:0] scans_per_second;
        logic [15:0] blink_show_at;
        logic [15:0] blink_period;
    } tod_cfg_t;

    typedef struct packed {
        logic [4:0] hours;
        logic [5:0] minutes;
        logic [5:0] seconds;
        mode_t      mode;
        logic       field_blanked;
    } tod_result_t;

    function automatic logic [5:0] wrap_up(input logic [5:0] v, input logic [5:0] limit);
        logic [6:0] inc;
        inc = {1'b0, v} + 7'd1;
        return (inc >= {1'b0, limit}) ? 6'd0 : inc[5:0];
    endfunction

    function automatic logic [5:0] wrap_down(input logic [5:0] v, input logic [5:0] limit);
        return (v == 6'd0 || v >= limit) ? (limit - 6'd1) : (v - 6'd1);
    endfunction

endpackage

/* src/settable_time_of_day_clock.sv */
// ----------------------------------------------------------------------------
// Settable time-of-day clock
// Keypad-driven clock: one result transaction per scan transaction.
// Result: registered in the output buffer, in its main entry or, while a result waits, in its skid entry.
// Throughput: one scan per cycle while results are taken; two results buffer.
// Reset: asynchronous, time 00:00:00, run mode, registers 10/20000/60000.
// ----------------------------------------------------------------------------
module settable_time_of_day_clock
    import tod_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  logic [4:0]           key_code,
    input  logic                 key_held,
    output logic                 out_valid,
    input  logic                 out_ready,
    output logic [4:0]           hours,
    output logic [5:0]           minutes,
    output logic [5:0]           seconds,
    output logic [1:0]           mode,
    output logic                 field_blanked,
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [15:0]          cfg_data
);

    tod_cfg_t    cfg;
    tod_result_t core_result;
    tod_result_t out_data;
    logic        step;

    assign step = in_valid && in_ready;

    tod_cfg_regs u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    tod_core u_core (
        .clk      (clk),
        .rst_n    (rst_n),
        .step     (step),
        .key_code (key_code),
        .key_held (key_held),
        .cfg      (cfg),
        .result   (core_result)
    );

    tod_out_buf u_out (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (step),
        .push_data  (core_result),
        .push_ready (in_ready),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .out_data   (out_data)
    );

    assign hours         = out_data.hours;
    assign minutes       = out_data.minutes;
    assign seconds       = out_data.seconds;
    assign mode          = out_data.mode;
    assign field_blanked = out_data.field_blanked;

endmodule

/* src/tod_cfg_regs.sv */
// ----------------------------------------------------------------------------
// Time-of-day clock configuration registers
// Holds the prescaler and blink settings written over the configuration port.
// ----------------------------------------------------------------------------
module tod_cfg_regs
    import tod_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [15:0]          cfg_data,
    output tod_cfg_t             cfg
);

    tod_cfg_t cfg_reg;
    tod_cfg_t cfg_next;

    assign cfg_ready = 1'b1;
    assign cfg       = cfg_reg;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_valid)
        begin
            case (cfg_index)
                CFG_SCANS_PER_SECOND: cfg_next.scans_per_second = cfg_data;
                CFG_BLINK_SHOW_AT:    cfg_next.blink_show_at    = cfg_data;
                CFG_BLINK_PERIOD:     cfg_next.blink_period     = cfg_data;
                default:              cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.scans_per_second <= SCANS_PER_SECOND_RST;
            cfg_reg.blink_show_at    <= BLINK_SHOW_AT_RST;
            cfg_reg.blink_period     <= BLINK_PERIOD_RST;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

endmodule

/* src/tod_core.sv */
// ----------------------------------------------------------------------------
// Time-of-day clock core
// Holds the time, mode, prescaler and blink state and updates them once per
// accepted keypad scan transaction.
// ----------------------------------------------------------------------------
module tod_core
    import tod_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        step,
    input  logic [4:0]  key_code,
    input  logic        key_held,
    input  tod_cfg_t    cfg,
    output tod_result_t result
);

    logic [15:0] pre_reg;
    logic [15:0] pre_next;
    logic [4:0]  hour_reg;
    logic [4:0]  hour_next;
    logic [5:0]  min_reg;
    logic [5:0]  min_next;
    logic [5:0]  sec_reg;
    logic [5:0]  sec_next;
    mode_t       mode_reg;
    mode_t       mode_next;
    logic [15:0] blink_reg;
    logic [15:0] blink_next;
    logic        blank_reg;
    logic        blank_next;

    logic [15:0] pre_inc;
    logic        tick;
    logic        sec_wrap;
    logic        min_wrap;
    logic [5:0]  sec_up;
    logic [5:0]  sec_dn;
    logic [5:0]  min_up;
    logic [5:0]  min_dn;
    logic [5:0]  hour_up;
    logic [5:0]  hour_dn;
    logic [5:0]  sec_tick;
    logic [5:0]  min_tick;
    logic [5:0]  hour_tick;
    logic [15:0] blink_base;

    assign pre_inc   = pre_reg + 16'd1;
    assign tick      = (pre_inc >= cfg.scans_per_second);
    assign sec_tick  = wrap_up(sec_reg, SECONDS_PER_MINUTE);
    assign min_tick  = wrap_up(min_reg, MINUTES_PER_HOUR);
    assign hour_tick = wrap_up({1'b0, hour_reg}, HOURS_PER_DAY);
    assign sec_wrap  = (sec_tick == 6'd0);
    assign min_wrap  = (min_tick == 6'd0);
    assign sec_up    = sec_tick;
    assign min_up    = min_tick;
    assign hour_up   = hour_tick;
    assign sec_dn    = wrap_down(sec_reg, SECONDS_PER_MINUTE);
    assign min_dn    = wrap_down(min_reg, MINUTES_PER_HOUR);
    assign hour_dn   = wrap_down({1'b0, hour_reg}, HOURS_PER_DAY);

    // mode sequencing
    always_comb
    begin
        mode_next = mode_reg;
        if (mode_reg == MODE_RUN)
        begin
            if (!key_held && key_code == KEY_MODE)
                mode_next = MODE_SET_SEC;
        end
        else if (!key_held)
        begin
            case (key_code)
                KEY_MODE: mode_next = MODE_RUN;
                KEY_NEXT: mode_next = mode_t'(mode_reg + 2'd1);
                KEY_PREV: mode_next = mode_t'(mode_reg - 2'd1);
                default:  mode_next = mode_reg;
            endcase
        end
    end

    // time, prescaler and blink
    always_comb
    begin
        pre_next   = pre_reg;
        hour_next  = hour_reg;
        min_next   = min_reg;
        sec_next   = sec_reg;
        blink_next = blink_reg;
        blank_next = blank_reg;
        blink_base = blink_reg;

        if (mode_reg == MODE_RUN)
        begin
            if (tick)
            begin
                pre_next = 16'd0;
                sec_next = sec_tick;
                if (sec_wrap)
                begin
                    min_next = min_tick;
                    if (min_wrap)
                        hour_next = hour_tick[4:0];
                end
            end
            else
            begin
                pre_next = pre_inc;
            end
        end
        else
        begin
            if (blink_reg == BLINK_BLANK_AT)
                blank_next = 1'b1;
            else if (blink_reg == cfg.blink_show_at)
                blank_next = 1'b0;
            else if (blink_reg == cfg.blink_period)
                blink_base = 16'd0;
            blink_next = blink_base + 16'd1;

            if (key_held)
            begin
                if (mode_reg == MODE_SET_SEC)
                    sec_next = sec_up;
            end
            else if (key_code == KEY_UP || key_code == KEY_DOWN)
            begin
                case (mode_reg)
                    MODE_SET_SEC:  sec_next  = (key_code == KEY_UP) ? sec_up : sec_dn;
                    MODE_SET_MIN:  min_next  = (key_code == KEY_UP) ? min_up : min_dn;
                    MODE_SET_HOUR: hour_next = (key_code == KEY_UP) ? hour_up[4:0]
                                                                     : hour_dn[4:0];
                    default:       sec_next  = sec_reg;
                endcase
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pre_reg   <= 16'd0;
            hour_reg  <= 5'd0;
            min_reg   <= 6'd0;
            sec_reg   <= 6'd0;
            mode_reg  <= MODE_RUN;
            blink_reg <= 16'd0;
            blank_reg <= 1'b0;
        end
        else if (step)
        begin
            pre_reg   <= pre_next;
            hour_reg  <= hour_next;
            min_reg   <= min_next;
            sec_reg   <= sec_next;
            mode_reg  <= mode_next;
            blink_reg <= blink_next;
            blank_reg <= blank_next;
        end
    end

    always_comb
    begin
        result.hours         = hour_next;
        result.minutes       = min_next;
        result.seconds       = sec_next;
        result.mode          = mode_next;
        result.field_blanked = (mode_next != MODE_RUN) && blank_next;
    end

endmodule

/* src/tod_out_buf.sv */
// ----------------------------------------------------------------------------
// Time-of-day clock result buffer
// Two-entry output register with skid entry; parts the scan input from the
// result output so a scan is taken while a result still waits.
// ----------------------------------------------------------------------------
module tod_out_buf
    import tod_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        push,
    input  tod_result_t push_data,
    output logic        push_ready,
    output logic        out_valid,
    input  logic        out_ready,
    output tod_result_t out_data
);

    logic        main_valid_reg;
    logic        main_valid_next;
    tod_result_t main_reg;
    tod_result_t main_next;
    logic        skid_valid_reg;
    logic        skid_valid_next;
    tod_result_t skid_reg;
    tod_result_t skid_next;
    logic        pop;

    assign push_ready = !skid_valid_reg;
    assign out_valid  = main_valid_reg;
    assign out_data   = main_reg;
    assign pop        = main_valid_reg && out_ready;

    always_comb
    begin
        main_valid_next = main_valid_reg;
        main_next       = main_reg;
        skid_valid_next = skid_valid_reg;
        skid_next       = skid_reg;
        if (skid_valid_reg)
        begin
            if (pop)
            begin
                main_next       = skid_reg;
                skid_valid_next = 1'b0;
            end
        end
        else if (push)
        begin
            if (!main_valid_reg || pop)
            begin
                main_next       = push_data;
                main_valid_next = 1'b1;
            end
            else
            begin
                skid_next       = push_data;
                skid_valid_next = 1'b1;
            end
        end
        else if (pop)
        begin
            main_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            main_valid_reg <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            main_valid_reg <= main_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        main_reg <= main_next;
        skid_reg <= skid_next;
    end

endmodule

/* src/tod_checker.sv */
// ----------------------------------------------------------------------------
// Time-of-day clock port checker
// Checks result ranges, blanking and buffering on the top-level ports.
// ----------------------------------------------------------------------------
module tod_checker
    import tod_pkg::*;
(
    input logic       clk,
    input logic       rst_n,
    input logic       in_ready,
    input logic       out_valid,
    input logic       out_ready,
    input logic [4:0] hours,
    input logic [5:0] minutes,
    input logic [5:0] seconds,
    input logic [1:0] mode,
    input logic       field_blanked
);

    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (hours < 5'd24) && (minutes < 6'd60) && (seconds < 6'd60))
        else $error("time field out of range");

    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && mode == MODE_RUN) |-> !field_blanked)
        else $error("field blanked in run mode");

    assert property (@(posedge clk) disable iff (!rst_n)
        !in_ready |-> out_valid)
        else $error("input stalled with no result pending");

    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_ready) |=> out_valid && $stable(hours) && $stable(minutes)
            && $stable(seconds) && $stable(mode) && $stable(field_blanked))
        else $error("stalled result transaction changed");

endmodule

bind settable_time_of_day_clock tod_checker u_tod_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_ready      (in_ready),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .hours         (hours),
    .minutes       (minutes),
    .seconds       (seconds),
    .mode          (mode),
    .field_blanked (field_blanked)
);

/* tb/sv/testbench.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Settable time-of-day clock testbench
// Feeds keypad scan transactions through valid/ready, models the run-mode
// prescaler, the setting modes and the blink counter scan by scan, and
// compares every result with the modelled time, mode and blank flag, or with
// a typed table row's result. A short table of directed scans and register
// writes comes first, then random setting sessions, end-of-day drills and
// stray keys under three register settings and three idling profiles.
// ----------------------------------------------------------------------------
module testbench;
    import tod_pkg::*;

    localparam logic [4:0]  KEY_NONE  = 5'd0;
    localparam logic [4:0]  KEY_STRAY = 5'd31;
    localparam logic [15:0] NO_DATA   = 16'd0;
    localparam int          LONG_HOLD = 300;

    typedef struct packed {
        bit                   is_write;
        logic [CFG_IDX_W-1:0] idx;
        logic [15:0]          data;
        logic [4:0]           key;
        logic                 held;
        bit                   typed;
        tod_result_t          want;
    } plan_row_t;

    localparam tod_result_t NO_CHECK    = '0;
    localparam tod_result_t AT_MIDNIGHT = '{5'd0, 6'd0, 6'd0, MODE_RUN, 1'b0};
    localparam tod_result_t ONE_SECOND  = '{5'd0, 6'd0, 6'd1, MODE_RUN, 1'b0};
    localparam tod_result_t SET_AT_TWO  = '{5'd0, 6'd0, 6'd2, MODE_SET_SEC, 1'b0};

    localparam plan_row_t DIRECTED_PLAN [28] = '{
        '{1'b0, CFG_SCANS_PER_SECOND, NO_DATA, KEY_NONE,  1'b0, 1'b1, AT_MIDNIGHT},
        '{1'b0, CFG_SCANS_PER_SECOND, NO_DATA, KEY_MODE,  1'b1, 1'b1, AT_MIDNIGHT},
        '{1'b1, CFG_SCANS_PER_SECOND, 16'd0,   KEY_NONE,  1'b0, 1'b0, NO_CHECK},
        '{1'b0, CFG_SCANS_PER_SECOND, NO_DATA, KEY_STRAY, 1'b0, 1'b1, ONE_SECOND},
        '{1'b1, CFG_BLINK_SHOW_AT,    16'd3,   KEY_NONE,  1'b0, 1'b0, NO_CHECK},
        '{1'b1, CFG_BLINK_PERIOD,     16'd4,   KEY_NONE,  1'b0, 1'b0, NO_CHECK},
        '{1'b0, CFG_SCANS_PER_SECOND, NO_DATA, KEY_MODE,  1'b0, 1'b1, SET_AT_TWO},
        '{1'b0, CFG_SCANS_PER_SECOND, NO_DATA, KEY_DOWN,  1'b0, 1'b0, NO_CHECK},
        '{1'b0, CFG_SCANS_PER_SECOND, NO_DATA, KEY_DOWN,  1'b0, 1'b0, NO_CHECK},
        '{1'b0, CFG_SCANS_PER_SECOND, NO_DATA, KEY_DOWN,  1'b0, 1'b0, NO_CHECK},
        '{1'b0, CFG_SCANS_PER_SECOND, NO_DATA, KEY_UP,    1'b0, 1'b0, NO_CHECK},
        '{1'b0, CFG_SCANS_PER_SECOND, NO_DATA, KEY_NONE,  1'b1, 1'b0, NO_CHECK},
        '{1'b0, CFG_SCANS_PER_SECOND, NO_DATA, KEY_NEXT,  1'b0, 1'b0, NO_CHECK},
        '{1'b0, CFG_SCANS_PER_SECOND, NO_DATA, KEY_DOWN,  1'b0, 1'b0, NO_CHECK},
        '{1'b0, CFG_SCANS_PER_SECOND, NO_DATA, KEY_UP,    1'b0, 1'b0, NO_CHECK},
        '{1'b0, CFG_SCANS_PER_SECOND, NO_DATA, KEY_NEXT,  1'b0, 1'b0, NO_CHECK},
        '{1'b0, CFG_SCANS_PER_SECOND, NO_DATA, KEY_DOWN,  1'b0, 1'b0, NO_CHECK},
        '{1'b0, CFG_SCANS_PER_SECOND, NO_DATA, KEY_UP,    1'b1, 1'b0, NO_CHECK},
        '{1'b0, CFG_SCANS_PER_SECOND, NO_DATA, KEY_STRAY, 1'b0, 1'b0, NO_CHECK},
        '{1'b0, CFG_SCANS_PER_SECOND, NO_DATA, KEY_PREV,  1'b0, 1'b0, NO_CHECK},
        '{1'b0, CFG_SCANS_PER_SECOND, NO_DATA, KEY_PREV,  1'b0, 1'b0, NO_CHECK},
        '{1'b0, CFG_SCANS_PER_SECOND, NO_DATA, KEY_PREV,  1'b0, 1'b0, NO_CHECK},
        '{1'b0, CFG_SCANS_PER_SECOND, NO_DATA, KEY_MODE,  1'b0, 1'b0, NO_CHECK},
        '{1'b0, CFG_SCANS_PER_SECOND, NO_DATA, KEY_NEXT,  1'b0, 1'b0, NO_CHECK},
        '{1'b0, CFG_SCANS_PER_SECOND, NO_DATA, KEY_NEXT,  1'b0, 1'b0, NO_CHECK},
        '{1'b0, CFG_SCANS_PER_SECOND, NO_DATA, KEY_NEXT,  1'b0, 1'b0, NO_CHECK},
        '{1'b0, CFG_SCANS_PER_SECOND, NO_DATA, KEY_MODE,  1'b0, 1'b0, NO_CHECK},
        '{1'b0, CFG_SCANS_PER_SECOND, NO_DATA, KEY_MODE,  1'b0, 1'b0, NO_CHECK}
    };

    logic                 clk = 1'b0;
    logic                 rst_n;
    logic                 in_valid;
    logic                 in_ready;
    logic [4:0]           key_code;
    logic                 key_held;
    logic                 out_valid;
    logic                 out_ready = 1'b0;
    logic [4:0]           hours;
    logic [5:0]           minutes;
    logic [5:0]           seconds;
    logic [1:0]           mode;
    logic                 field_blanked;
    logic                 cfg_valid;
    logic                 cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [15:0]          cfg_data;

    tod_cfg_t    clock_regs = '{SCANS_PER_SECOND_RST, BLINK_SHOW_AT_RST, BLINK_PERIOD_RST};
    logic [15:0] scan_count = '0;
    int          hh = 0;
    int          mm = 0;
    int          ss = 0;
    mode_t       mode_now = MODE_RUN;
    logic [15:0] flash_count = '0;
    logic        blanked = 1'b0;

    tod_result_t pending_readings [$];
    int          mismatch_count = 0;
    int          scans_sent = 0;
    int          tx_idle_pct = 22;
    int          rx_idle_pct = 73;
    bit          hold_request = 1'b0;
    int          hold_left = 0;

    settable_time_of_day_clock DUT (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .key_code      (key_code),
        .key_held      (key_held),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .hours         (hours),
        .minutes       (minutes),
        .seconds       (seconds),
        .mode          (mode),
        .field_blanked (field_blanked),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    always #10 clk = ~clk;

    function automatic int wrap_step(input int v, input int lim, input bit up);
        if (up)
            return (v + 1 >= lim) ? 0 : v + 1;
        return (v == 0 || v >= lim) ? lim - 1 : v - 1;
    endfunction

    function automatic tod_result_t predict_scan(input logic [4:0] k, input logic h);
        tod_result_t r;
        logic [1:0]  m2;
        if (mode_now == MODE_RUN)
        begin
            scan_count = scan_count + 16'd1;
            if (scan_count >= clock_regs.scans_per_second)
            begin
                scan_count = '0;
                ss = ss + 1;
                if (ss >= int'(SECONDS_PER_MINUTE))
                begin
                    ss = 0;
                    mm = mm + 1;
                    if (mm >= int'(MINUTES_PER_HOUR))
                    begin
                        mm = 0;
                        hh = hh + 1;
                        if (hh >= int'(HOURS_PER_DAY))
                            hh = 0;
                    end
                end
            end
            if (!h && k == KEY_MODE)
                mode_now = MODE_SET_SEC;
        end
        else
        begin
            if (flash_count == BLINK_BLANK_AT)
                blanked = 1'b1;
            else if (flash_count == clock_regs.blink_show_at)
                blanked = 1'b0;
            else if (flash_count == clock_regs.blink_period)
                flash_count = '0;
            flash_count = flash_count + 16'd1;

            if (h)
            begin
                if (mode_now == MODE_SET_SEC)
                    ss = wrap_step(ss, int'(SECONDS_PER_MINUTE), 1'b1);
            end
            else
            begin
                case (k)
                    KEY_MODE: mode_now = MODE_RUN;
                    KEY_UP, KEY_DOWN:
                    begin
                        if (mode_now == MODE_SET_SEC)
                            ss = wrap_step(ss, int'(SECONDS_PER_MINUTE), k == KEY_UP);
                        else if (mode_now == MODE_SET_MIN)
                            mm = wrap_step(mm, int'(MINUTES_PER_HOUR), k == KEY_UP);
                        else
                            hh = wrap_step(hh, int'(HOURS_PER_DAY), k == KEY_UP);
                    end
                    KEY_NEXT:
                    begin
                        m2 = mode_now + 2'd1;
                        mode_now = mode_t'(m2);
                    end
                    KEY_PREV:
                    begin
                        m2 = mode_now - 2'd1;
                        mode_now = mode_t'(m2);
                    end
                    default: ;
                endcase
            end
        end
        r.hours         = hh[4:0];
        r.minutes       = mm[5:0];
        r.seconds       = ss[5:0];
        r.mode          = mode_now;
        r.field_blanked = (mode_now != MODE_RUN) && blanked;
        return r;
    endfunction

    task automatic send_scan(input logic [4:0] k, input logic h, input bit typed,
                             input tod_result_t want);
        tod_result_t predicted;
        while ($urandom_range(0, 99) < tx_idle_pct)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid <= 1'b1;
        key_code <= k;
        key_held <= h;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        predicted = predict_scan(k, h);
        pending_readings.push_back(typed ? want : predicted);
        scans_sent++;
        @(negedge clk);
    endtask

    task automatic press(input logic [4:0] k, input logic h);
        send_scan(k, h, 1'b0, NO_CHECK);
    endtask

    task automatic write_register(input logic [CFG_IDX_W-1:0] idx, input logic [15:0] value);
        in_valid <= 1'b0;
        while (pending_readings.size() != 0)
            @(negedge clk);
        repeat (4) @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        case (idx)
            CFG_SCANS_PER_SECOND: clock_regs.scans_per_second = value;
            CFG_BLINK_SHOW_AT:    clock_regs.blink_show_at = value;
            CFG_BLINK_PERIOD:     clock_regs.blink_period = value;
            default: ;
        endcase
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    task automatic setting_session();
        int choice;
        if (mode_now == MODE_RUN)
            press(KEY_MODE, 1'b0);
        repeat ($urandom_range(1, 12))
        begin
            choice = $urandom_range(0, 99);
            if (choice < 30)
                press(KEY_UP, 1'b0);
            else if (choice < 55)
                press(KEY_DOWN, 1'b0);
            else if (choice < 65)
                press(5'($urandom_range(0, 31)), 1'b1);
            else if (choice < 75)
                press(KEY_NEXT, 1'b0);
            else if (choice < 82)
                press(KEY_PREV, 1'b0);
            else if (choice < 90)
                press(KEY_NONE, 1'b0);
            else
                press(5'($urandom_range(0, 31)), 1'b0);
        end
        if (mode_now != MODE_RUN && $urandom_range(0, 1) == 0)
            press(KEY_MODE, 1'b0);
        while (mode_now != MODE_RUN)
            press(KEY_NEXT, 1'b0);
        repeat ($urandom_range(0, 8))
            press(KEY_NONE, 1'b0);
    endtask

    task automatic end_of_day_drill();
        while (mode_now != MODE_SET_SEC)
            press(mode_now == MODE_RUN ? KEY_MODE : KEY_NEXT, 1'b0);
        while (ss != 59)
            press(KEY_DOWN, 1'b0);
        press(KEY_NEXT, 1'b0);
        while (mm != 59)
            press(KEY_DOWN, 1'b0);
        press(KEY_NEXT, 1'b0);
        while (hh != 23)
            press(KEY_DOWN, 1'b0);
        press(KEY_NEXT, 1'b0);
        repeat ($urandom_range(1, 4))
            press(KEY_NONE, 1'b0);
    endtask

    always @(negedge clk)
    begin
        if (hold_left > 0)
        begin
            hold_left--;
            out_ready <= 1'b0;
        end
        else if (hold_request)
        begin
            hold_request = 1'b0;
            hold_left = LONG_HOLD;
            out_ready <= 1'b0;
        end
        else
            out_ready <= ($urandom_range(0, 99) >= rx_idle_pct);
    end

    always @(posedge clk)
    begin
        tod_result_t got;
        tod_result_t want;
        if (rst_n && out_valid && out_ready)
        begin
            got = '{hours, minutes, seconds, mode_t'(mode), field_blanked};
            if (pending_readings.size() == 0)
            begin
                $display("%0t: unexpected result %0d:%0d:%0d mode %0d blank %0d",
                         $time, got.hours, got.minutes, got.seconds, got.mode,
                         got.field_blanked);
                mismatch_count++;
            end
            else
            begin
                want = pending_readings.pop_front();
                if (got !== want)
                begin
                    $display("%0t: expected %0d:%0d:%0d mode %0d blank %0d, got %0d:%0d:%0d mode %0d blank %0d",
                             $time, want.hours, want.minutes, want.seconds, want.mode,
                             want.field_blanked, got.hours, got.minutes, got.seconds,
                             got.mode, got.field_blanked);
                    mismatch_count++;
                end
            end
        end
    end

    initial
    begin
        #5_000_000;
        $display("CHECK FAILED");
        $finish;
    end

    initial
    begin
        int          target;
        int          choice;
        logic [15:0] show;
        rst_n     = 1'b0;
        in_valid  = 1'b0;
        key_code  = KEY_NONE;
        key_held  = 1'b0;
        cfg_valid = 1'b0;
        cfg_index = CFG_SCANS_PER_SECOND;
        cfg_data  = '0;
        repeat (8) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        for (int i = 0; i < $size(DIRECTED_PLAN); i++)
        begin
            if (DIRECTED_PLAN[i].is_write)
                write_register(DIRECTED_PLAN[i].idx, DIRECTED_PLAN[i].data);
            else
                send_scan(DIRECTED_PLAN[i].key, DIRECTED_PLAN[i].held,
                          DIRECTED_PLAN[i].typed, DIRECTED_PLAN[i].want);
        end

        for (int phase = 0; phase < 3; phase++)
        begin
            case (phase)
                0:
                begin
                    tx_idle_pct = 22;
                    rx_idle_pct = 73;
                    write_register(CFG_SCANS_PER_SECOND, 16'd1);
                    write_register(CFG_BLINK_SHOW_AT, 16'd2);
                    write_register(CFG_BLINK_PERIOD, 16'd3);
                end
                1:
                begin
                    tx_idle_pct = 73;
                    rx_idle_pct = 22;
                    write_register(CFG_SCANS_PER_SECOND, 16'hFFFF);
                    write_register(CFG_BLINK_SHOW_AT, 16'hFFFF);
                    write_register(CFG_BLINK_PERIOD, 16'hFFFF);
                end
                default:
                begin
                    tx_idle_pct = 0;
                    rx_idle_pct = 0;
                    show = 16'($urandom_range(2, 40));
                    write_register(CFG_SCANS_PER_SECOND, 16'($urandom_range(0, 4)));
                    write_register(CFG_BLINK_SHOW_AT, show);
                    write_register(CFG_BLINK_PERIOD,
                                   ($urandom_range(0, 3) == 0) ? show
                                                               : 16'($urandom_range(3, 40)));
                    hold_request = 1'b1;
                end
            endcase
            target = scans_sent + 200;
            while (scans_sent < target)
            begin
                choice = $urandom_range(0, 99);
                if (choice < 8)
                    end_of_day_drill();
                else if (choice < 75)
                    setting_session();
                else
                    repeat ($urandom_range(1, 6))
                        press(5'($urandom_range(0, 31)), 1'($urandom_range(0, 1)));
            end
        end

        in_valid <= 1'b0;
        while (pending_readings.size() != 0)
            @(negedge clk);
        repeat (10) @(posedge clk);
        if (mismatch_count == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule

/* files.f */
src/tod_pkg.sv
src/tod_cfg_regs.sv
src/tod_core.sv
src/tod_out_buf.sv
src/settable_time_of_day_clock.sv
src/tod_checker.sv
tb/sv/testbench.sv
